// ----- hw/rtl/ptm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptm_pkg
// Types and constants shared by the process table blocks.
// ----------------------------------------------------------------------------
package ptm_pkg;

  localparam int NUM_SLOTS     = 16;
  localparam int MAILBOX_DEPTH = 8;
  localparam int SLOT_W        = $clog2(NUM_SLOTS);
  localparam int MB_W          = $clog2(MAILBOX_DEPTH);
  localparam int CNT_W         = $clog2(MAILBOX_DEPTH + 1);
  localparam int STORE_DEPTH   = NUM_SLOTS * MAILBOX_DEPTH;
  localparam int STORE_AW      = $clog2(STORE_DEPTH);

  localparam logic [7:0] NO_PARENT        = 8'hFF;
  localparam logic [7:0] DEFAULT_PRIO_RST = 8'd128;

  typedef enum logic [1:0] {
    ST_DEAD     = 2'd0,
    ST_READY    = 2'd1,
    ST_SLEEPING = 2'd2,
    ST_BLOCKED  = 2'd3
  } slot_state_t;

  typedef enum logic [3:0] {
    ACT_PARENT  = 4'd0,
    ACT_ID      = 4'd1,
    ACT_PRIO    = 4'd2,
    ACT_SETPRIO = 4'd3,
    ACT_SLEEP   = 4'd4,
    ACT_KILL    = 4'd5,
    ACT_YIELD   = 4'd6,
    ACT_SUSPEND = 4'd7,
    ACT_WAKE    = 4'd8,
    ACT_CREATE  = 4'd9,
    ACT_SEND    = 4'd10,
    ACT_CHECK   = 4'd11,
    ACT_POP     = 4'd12,
    ACT_QUIT    = 4'd13,
    ACT_RSV14   = 4'd14,
    ACT_RSV15   = 4'd15
  } action_t;

  typedef enum logic [3:0] {
    STS_OK       = 4'd0,
    STS_BAD_PRIO = 4'd1,
    STS_BAD_PID  = 4'd2,
    STS_DEAD     = 4'd3,
    STS_SELF     = 4'd4,
    STS_BLOCKED  = 4'd5,
    STS_SLEEPING = 4'd6,
    STS_NOT_BLK  = 4'd7,
    STS_FULL     = 4'd8,
    STS_MB_FULL  = 4'd9,
    STS_EMPTY    = 4'd10
  } status_t;

  localparam logic [1:0] REG_LOWEST  = 2'd0;
  localparam logic [1:0] REG_HIGHEST = 2'd1;
  localparam logic [1:0] REG_DEFAULT = 2'd2;

  typedef struct packed {
    logic [3:0]         action;
    logic [3:0]         caller;
    logic [7:0]         target_pid;
    logic signed [15:0] priority_value;
    logic [15:0]        start_pc;
    logic [15:0]        wait_ms;
    logic [7:0]         msg_content;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] value;
  } out_item_t;

  // Classified command handed from front to back.
  typedef struct packed {
    action_t     action;
    logic [3:0]  caller;
    logic [7:0]  target_pid;
    logic        prio_ok;
    logic [7:0]  prio;
    logic [15:0] start_pc;
    logic [15:0] wait_ms;
    logic [7:0]  msg_content;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_READ = 2'd1,
    BK_OUT  = 2'd2
  } back_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ptm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ptm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ptm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptm_front
// Accepts command beats, checks the priority range and pushes classified
// commands into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ptm_front
  import ptm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire logic [7:0] lowest_priority,
  input  wire logic [7:0] highest_priority,
  output logic          q_valid,
  input  wire logic     q_pop,
  output cmd_t          q_data
);

  cmd_t       q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       ge_lo;
  logic       le_hi;
  cmd_t       cmd;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;

  // 17-bit signed compares against the unsigned bounds
  assign ge_lo = $signed({in_data.priority_value[15], in_data.priority_value})
                 >= $signed({9'd0, lowest_priority});
  assign le_hi = $signed({in_data.priority_value[15], in_data.priority_value})
                 <= $signed({9'd0, highest_priority});

  always_comb begin
    cmd.action      = action_t'(in_data.action);
    cmd.caller      = in_data.caller;
    cmd.target_pid  = in_data.target_pid;
    cmd.prio_ok     = ge_lo && le_hi;
    cmd.prio        = in_data.priority_value[7:0];
    cmd.start_pc    = in_data.start_pc;
    cmd.wait_ms     = in_data.wait_ms;
    cmd.msg_content = in_data.msg_content;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assign q_valid = (count != 2'd0);
  assign q_data  = q_mem[rd_ptr];

endmodule

`default_nettype wire

// ----- hw/rtl/ptm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptm_back
// Executes commands against the slot table and mailbox store, and holds the
// result beat in an output register.
// ----------------------------------------------------------------------------
module ptm_back
  import ptm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_valid,
  output logic           q_pop,
  input  wire cmd_t      q_data,
  input  wire logic [7:0] default_priority,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  slot_state_t       slot_state    [NUM_SLOTS];
  logic [7:0]        slot_priority [NUM_SLOTS];
  logic [7:0]        slot_parent   [NUM_SLOTS];
  logic [15:0]       slot_entry    [NUM_SLOTS];
  logic [15:0]       slot_wait     [NUM_SLOTS];
  logic [CNT_W-1:0]  slot_count    [NUM_SLOTS];

  back_state_t state;
  back_state_t state_next;
  cmd_t        cur;

  logic              res_valid;
  out_item_t         res_data;

  logic [3:0]        status;
  logic [15:0]       value;
  logic              caller_ok;
  logic              tgt_ok;
  logic [SLOT_W-1:0] ci;
  logic [SLOT_W-1:0] ti;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              pop_read;

  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr;
  logic [STORE_AW-1:0] ram_raddr;
  logic [15:0]         ram_rdata;

  assign ci        = cur.caller[SLOT_W-1:0];
  assign ti        = cur.target_pid[SLOT_W-1:0];
  assign caller_ok = {4'd0, cur.caller} < 8'(NUM_SLOTS);
  assign tgt_ok    = cur.target_pid < 8'(NUM_SLOTS);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (slot_state[s] == ST_DEAD) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(s);
      end
    end
  end

  // decision for the command in cur (evaluated in BK_READ)
  always_comb begin
    status   = STS_OK;
    value    = '0;
    pop_read = 1'b0;
    unique case (cur.action)
      ACT_PARENT: begin
        if (!caller_ok) status = STS_BAD_PID;
        else value = {8'd0, slot_parent[ci]};
      end
      ACT_ID: value = {12'd0, cur.caller};
      ACT_PRIO: begin
        if (!caller_ok) status = STS_BAD_PID;
        else value = {8'd0, slot_priority[ci]};
      end
      ACT_SETPRIO: begin
        if (!cur.prio_ok) status = STS_BAD_PRIO;
        else if (!tgt_ok) status = STS_BAD_PID;
        else if (slot_state[ti] == ST_DEAD) status = STS_DEAD;
      end
      ACT_SLEEP, ACT_CHECK, ACT_QUIT: begin
        if (!caller_ok) status = STS_BAD_PID;
        else if (cur.action == ACT_CHECK) value = {15'd0, slot_count[ci] != '0};
      end
      ACT_KILL, ACT_SUSPEND, ACT_WAKE: begin
        if (cur.target_pid == {4'd0, cur.caller}) status = STS_SELF;
        else if (!tgt_ok) status = STS_BAD_PID;
        else if (slot_state[ti] == ST_DEAD) status = STS_DEAD;
        else if (cur.action == ACT_SUSPEND) begin
          if (slot_state[ti] == ST_BLOCKED) status = STS_BLOCKED;
          else if (slot_state[ti] == ST_SLEEPING) status = STS_SLEEPING;
        end else if (cur.action == ACT_WAKE) begin
          if (slot_state[ti] != ST_BLOCKED) status = STS_NOT_BLK;
        end
      end
      ACT_CREATE: begin
        if (!cur.prio_ok) status = STS_BAD_PRIO;
        else if (!free_found) status = STS_FULL;
        else value = {{(16 - SLOT_W){1'b0}}, free_idx};
      end
      ACT_SEND: begin
        if (!tgt_ok) status = STS_BAD_PID;
        else if (slot_state[ti] == ST_DEAD) status = STS_DEAD;
        else if (slot_count[ti] >= CNT_W'(MAILBOX_DEPTH)) status = STS_MB_FULL;
      end
      ACT_POP: begin
        if (!caller_ok) status = STS_BAD_PID;
        else if (slot_count[ci] == '0) status = STS_EMPTY;
        else pop_read = 1'b1;
      end
      default: ;
    endcase
  end

  // mailbox store: read address set up while the command is latched
  assign ram_raddr = {ci, MB_W'(slot_count[ci] - 1'b1)};
  assign ram_waddr = {ti, slot_count[ti][MB_W-1:0]};
  assign ram_we    = (state == BK_READ) && (cur.action == ACT_SEND) && (status == STS_OK);

  ptm_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({cur.msg_content, 4'd0, cur.caller}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (q_valid) state_next = BK_READ;
      BK_READ: state_next = BK_OUT;
      BK_OUT:  if (!res_valid || !out_stall) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  assign q_pop = (state == BK_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  // slot table update and pending result
  logic [3:0]  pend_status;
  logic        pend_pop;
  logic [15:0] pend_value;

  always_ff @(posedge clk) begin
    if (state == BK_READ) begin
      pend_status <= status;
      pend_value  <= value;
      pend_pop    <= pop_read;
    end else if (state == BK_OUT && pend_pop) begin
      // the read address moves once the count drops, so keep the word
      pend_value <= ram_rdata;
      pend_pop   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_state[s]    <= ST_DEAD;
        slot_priority[s] <= DEFAULT_PRIO_RST;
        slot_parent[s]   <= NO_PARENT;
        slot_entry[s]    <= '0;
        slot_wait[s]     <= '0;
        slot_count[s]    <= '0;
      end
    end else if (state == BK_READ && status == STS_OK) begin
      unique case (cur.action)
        ACT_SETPRIO: slot_priority[ti] <= cur.prio;
        ACT_SLEEP: begin
          slot_state[ci] <= ST_SLEEPING;
          slot_wait[ci]  <= cur.wait_ms;
        end
        ACT_KILL, ACT_QUIT: begin
          if (cur.action == ACT_KILL) begin
            slot_state[ti]    <= ST_DEAD;
            slot_priority[ti] <= default_priority;
            slot_parent[ti]   <= NO_PARENT;
            slot_entry[ti]    <= '0;
            slot_wait[ti]     <= '0;
            slot_count[ti]    <= '0;
          end else begin
            slot_state[ci]    <= ST_DEAD;
            slot_priority[ci] <= default_priority;
            slot_parent[ci]   <= NO_PARENT;
            slot_entry[ci]    <= '0;
            slot_wait[ci]     <= '0;
            slot_count[ci]    <= '0;
          end
        end
        ACT_SUSPEND: slot_state[ti] <= ST_BLOCKED;
        ACT_WAKE:    slot_state[ti] <= ST_READY;
        ACT_CREATE: begin
          slot_parent[free_idx]   <= {4'd0, cur.caller};
          slot_entry[free_idx]    <= cur.start_pc;
          slot_priority[free_idx] <= cur.prio;
          slot_state[free_idx]    <= ST_READY;
        end
        ACT_SEND: slot_count[ti] <= slot_count[ti] + 1'b1;
        ACT_POP:  slot_count[ci] <= slot_count[ci] - 1'b1;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == BK_OUT && (!res_valid || !out_stall)) begin
      res_valid <= 1'b1;
    end else if (!out_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_OUT && (!res_valid || !out_stall)) begin
      res_data.status <= pend_status;
      res_data.value  <= pend_pop ? ram_rdata : pend_value;
    end
  end

  assign out_valid = res_valid;
  assign out_data  = res_data;

endmodule

`default_nettype wire

// ----- hw/rtl/process_table_with_mailboxes.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// process_table_with_mailboxes
// Process table with per-slot LIFO mailboxes, one result beat per command.
// ----------------------------------------------------------------------------
// Each command beat yields one result beat. The front end checks the priority
// range and queues up to two commands; the back end steps each command through
// latch, table update with mailbox access and result register, and takes no
// new command until the last one's result is registered, which waits while a
// stalled result holds the output. The mailbox store needs no clearing pass
// after reset.
module process_table_with_mailboxes
  import ptm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] lowest_priority;
  logic [7:0] highest_priority;
  logic [7:0] default_priority;
  logic       q_valid;
  logic       q_pop;
  cmd_t       q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_priority  <= 8'd0;
      highest_priority <= 8'd255;
      default_priority <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOWEST:  lowest_priority  <= cfg_data;
        REG_HIGHEST: highest_priority <= cfg_data;
        REG_DEFAULT: default_priority <= cfg_data;
        default: ;
      endcase
    end
  end

  ptm_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .lowest_priority  (lowest_priority),
    .highest_priority (highest_priority),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_data           (q_data)
  );

  ptm_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_data           (q_data),
    .default_priority (default_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data)
  );

  // a result beat that is stalled must hold
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // the queue only hands over when it holds something
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");

  // a non-ok status always carries value zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STS_OK |-> out_data.value == 16'd0)
    else $error("error status with nonzero value");

endmodule

`default_nettype wire
